// ===== hdl/csr_row_multiply_accumulate_top_macros.svh =====
// ----------------------------------------------------------------------------
// csr row multiply-accumulate assertion macros
// shared property shorthands, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef CSR_ROW_MULTIPLY_ACCUMULATE_TOP_MACROS_SVH
`define CSR_ROW_MULTIPLY_ACCUMULATE_TOP_MACROS_SVH

// same-cycle implication
`define CRM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/csr_rmac_pkg.sv =====
// ----------------------------------------------------------------------------
// csr_rmac_pkg
// request codes, queue sizing and the front-to-back operation record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csr_rmac_pkg;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_NONZERO = 2'd1;
  localparam logic [1:0] REQ_EMPTY   = 2'd2;

  // index zero-extended to cover any store depth up to 65536
  localparam int IDX_EXT_W = 17;

  localparam int FIFO_DEPTH = 4;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_MAC    = 1'b0,
    OP_FINISH = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              last;
    logic signed [31:0] value;
    logic signed [31:0] elem;
    logic signed [31:0] base;
  } back_op_t;

endpackage

`default_nettype wire

// ===== hdl/csr_rmac_front.sv =====
// ----------------------------------------------------------------------------
// csr_rmac_front
// accepts requests, owns the source vector store, issues row operations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csr_rmac_front import csr_rmac_pkg::*; #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [9:0]         index,
  input  logic signed [31:0] value,
  input  logic               row_last,
  input  logic signed [31:0] row_base,
  output logic               push,
  output back_op_t           push_op,
  input  logic               full
);

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  localparam logic [IDX_EXT_W-1:0] DEPTH_L = IDX_EXT_W'(VECTOR_DEPTH);

  logic [31:0] mem [VECTOR_DEPTH];

  logic [IDX_EXT_W-1:0] index_ext;
  logic [ADDR_W-1:0]    addr;
  logic                 in_range;
  logic                 accept;
  logic                 is_op;

  logic               s1_valid;
  op_kind_t           s1_kind;
  logic               s1_last;
  logic signed [31:0] s1_value;
  logic signed [31:0] s1_base;
  logic               s1_in_range;
  logic signed [31:0] rd_data;

  assign index_ext = IDX_EXT_W'(index);
  assign addr      = index_ext[ADDR_W-1:0];
  assign in_range  = index_ext < DEPTH_L;

  assign in_ready = !s1_valid || !full;
  assign accept   = in_valid && in_ready;
  assign is_op    = (req_type == REQ_NONZERO) || (req_type == REQ_EMPTY);
  assign push     = s1_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_op;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_op) begin
      s1_kind     <= (req_type == REQ_NONZERO) ? OP_MAC : OP_FINISH;
      s1_last     <= row_last;
      s1_value    <= value;
      s1_base     <= row_base;
      s1_in_range <= in_range;
    end
  end

  // vector store: written on an accepted in-range write request, read on an accepted nonzero request
  always_ff @(posedge clk) begin
    if (accept && (req_type == REQ_WRITE) && in_range) begin
      mem[addr] <= value;
    end
    if (accept && (req_type == REQ_NONZERO)) begin
      rd_data <= mem[addr];
    end
  end

  always_comb begin
    push_op.kind  = s1_kind;
    push_op.last  = s1_last;
    push_op.value = s1_value;
    // columns beyond the store read as zero
    push_op.elem  = s1_in_range ? rd_data : '0;
    push_op.base  = s1_base;
  end

endmodule

`default_nettype wire

// ===== hdl/csr_rmac_fifo.sv =====
// ----------------------------------------------------------------------------
// csr_rmac_fifo
// short operation queue between the front and the arithmetic back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "csr_row_multiply_accumulate_top_macros.svh"

module csr_rmac_fifo import csr_rmac_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  back_op_t push_op,
  output logic     full,
  input  logic     pop,
  output back_op_t head,
  output logic     empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(FIFO_DEPTH);

  back_op_t slots [FIFO_DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic [PTR_W:0]   count_next;

  assign full  = count == FULL_COUNT;
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  `CRM_ASSERT_IMPLIES(a_no_overflow, push, !full, "push into a full queue")
  `CRM_ASSERT_IMPLIES(a_no_underflow, pop, !empty, "pop from an empty queue")
  `CRM_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

// ===== hdl/csr_rmac_back.sv =====
// ----------------------------------------------------------------------------
// csr_rmac_back
// multiply, row accumulate, residual and saturation with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "csr_row_multiply_accumulate_top_macros.svh"

module csr_rmac_back import csr_rmac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  logic               fifo_empty,
  input  back_op_t           head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] row_result,
  output logic               saturated
);

  logic adv;

  logic               b1_valid;
  op_kind_t           b1_kind;
  logic               b1_last;
  logic signed [63:0] b1_prod;
  logic signed [31:0] b1_base;

  logic signed [63:0] acc;
  logic signed [63:0] sum;

  logic               fin_valid;
  logic signed [63:0] fin_sum;
  logic signed [31:0] fin_base;

  logic signed [63:0] resid;
  logic               sat_hi;
  logic               sat_lo;

  // whole back end moves together when the output register can take data
  assign adv = !out_valid || out_ready;
  assign pop = adv && !fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (adv) begin
      b1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_kind <= head.kind;
      b1_last <= head.last;
      b1_prod <= 64'(head.value) * 64'(head.elem);
      b1_base <= head.base;
    end
  end

  // round half up to q16.16: floor shift plus bit 15 as carry in
  assign sum = acc + (b1_prod >>> 16) + $signed({63'b0, b1_prod[15]});

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= 1'b0;
      if (b1_valid) begin
        if ((b1_kind == OP_FINISH) || b1_last) begin
          fin_valid <= 1'b1;
          acc       <= '0;
        end else begin
          acc <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b1_valid) begin
      fin_sum  <= (b1_kind == OP_FINISH) ? acc : sum;
      fin_base <= b1_base;
    end
  end

  assign resid  = mode ? (64'(fin_base) - fin_sum) : fin_sum;
  assign sat_hi = !resid[63] && (|resid[62:31]);
  assign sat_lo = resid[63] && !(&resid[62:31]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_valid) begin
      if (sat_hi) begin
        row_result <= SAT_MAX;
      end else if (sat_lo) begin
        row_result <= SAT_MIN;
      end else begin
        row_result <= resid[31:0];
      end
      saturated <= sat_hi || sat_lo;
    end
  end

  `CRM_ASSERT_NEXT(a_acc_clear, adv && b1_valid && (b1_kind == OP_FINISH || b1_last), acc == '0, "accumulator not cleared at row end")
  `CRM_ASSERT_NEXT(a_fin_hold, fin_valid && !adv, fin_valid && $stable(fin_sum), "pending row sum lost in stall")
  `CRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(row_result), "row result changed in stall")

endmodule

`default_nettype wire

// ===== hdl/csr_row_multiply_accumulate_top.sv =====
// ----------------------------------------------------------------------------
// csr_row_multiply_accumulate_top
// streaming csr sparse matrix times vector, q16.16, with residual mode
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | req_type, index, value, row_last, row_base
//  out      | out_valid / out_ready| row_result, saturated
//  cfg      | cfg_valid / cfg_ready| cfg_data (mode)
//
//  one request per cycle sustained while out_ready holds; out_valid rises once the
//  last request of a row has passed the store read, queue, multiply,
//  accumulate and saturate registers
//  reset clears control state and the accumulator; the vector store is not
//  cleared and an element must be written before it is read
//  an output stall freezes the back end; the four-entry queue absorbs it
//  before in_ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csr_row_multiply_accumulate_top import csr_rmac_pkg::*; #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [9:0]         index,
  input  logic signed [31:0] value,
  input  logic               row_last,
  input  logic signed [31:0] row_base,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] row_result,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic     mode;
  logic     push;
  back_op_t push_op;
  logic     full;
  logic     pop;
  back_op_t head;
  logic     empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  csr_rmac_front #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .index    (index),
    .value    (value),
    .row_last (row_last),
    .row_base (row_base),
    .push     (push),
    .push_op  (push_op),
    .full     (full)
  );

  csr_rmac_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .head    (head),
    .empty   (empty)
  );

  csr_rmac_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .fifo_empty (empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_result (row_result),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire
